FILE: rtl/console_line_edit_buffer_macros.svh
`ifndef CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH
`define CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CLB_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("clb assertion failed");

// next-cycle implication, checked out of reset
`define CLB_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("clb assertion failed");

`endif

FILE: rtl/clb_pkg.sv
package clb_pkg;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ECHO  = 3'd1,
    KIND_ERASE = 3'd2,
    KIND_DATA  = 3'd3,
    KIND_EOF   = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_NONE   = 8'hFF;

  localparam logic [7:0] ERASE_MAX = 8'hFF;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] erase;
    logic       done;
    logic       ready;
  } res_t;

endpackage

FILE: rtl/clb_ram.sv
module clb_ram
  import clb_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/clb_ctrl.sv
`include "console_line_edit_buffer_macros.svh"

module clb_ctrl
  import clb_pkg::*;
#(
  parameter int BUF_DEPTH = 128,
  parameter int AW        = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_accept_i,
  input  logic          cmd_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          first_of_read_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output res_t          res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);

  localparam int IW = AW + 1;
  localparam logic [IW-1:0] IDX_MAX = IW'(2 * BUF_DEPTH - 1);
  localparam logic [IW-1:0] DEPTH_I = IW'(BUF_DEPTH);

  function automatic logic [IW-1:0] idx_inc(logic [IW-1:0] v);
    return (v == IDX_MAX) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(logic [IW-1:0] v);
    return (v == '0) ? IDX_MAX : v - IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_diff(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] t;
    t = {1'b0, a} + (IW+1)'(2 * BUF_DEPTH) - {1'b0, b};
    return (a >= b) ? a - b : IW'(t);
  endfunction

  function automatic logic [AW-1:0] slot(logic [IW-1:0] v);
    return (v >= DEPTH_I) ? AW'(v - DEPTH_I) : AW'(v);
  endfunction

  state_e        state_q, state_d;
  logic [IW-1:0] read_q, read_d;
  logic [IW-1:0] commit_q, commit_d;
  logic [IW-1:0] edit_q, edit_d;
  logic          first_q, first_d;
  logic [IW-1:0] kill_n;
  logic [IW-1:0] edit_nxt;
  logic [7:0]    ch;
  logic [7:0]    rb;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i && cmd_i == CMD_READ && read_q != commit_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_NONE;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot(edit_q);
    mem_re_o    = 1'b0;
    mem_raddr_o = slot(read_q);
    kill_n      = idx_diff(edit_q, commit_q);
    edit_nxt    = idx_inc(edit_q);
    ch          = (rx_byte_i == CH_CR) ? CH_LF : rx_byte_i;
    mem_wdata_o = ch;
    rb          = mem_rdata_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          res_valid_o = 1'b1;
          if (cmd_i == CMD_RX) begin
            priority if (rx_byte_i == CH_CTRL_U) begin
              edit_d = commit_q;
              if (kill_n != '0) begin
                res_o.kind  = KIND_ERASE;
                res_o.erase = (32'(kill_n) > 32'(ERASE_MAX)) ? ERASE_MAX : 8'(kill_n);
              end
            end else if (rx_byte_i == CH_CTRL_H || rx_byte_i == CH_DEL) begin
              if (edit_q != commit_q) begin
                edit_d      = idx_dec(edit_q);
                res_o.kind  = KIND_ERASE;
                res_o.erase = 8'd1;
              end
            end else if (rx_byte_i == CH_NUL || rx_byte_i == CH_NONE ||
                         rx_byte_i == CH_CTRL_P) begin
              res_o.kind = KIND_NONE;
            end else begin
              if (idx_diff(edit_q, read_q) < DEPTH_I) begin
                mem_we_o   = 1'b1;
                edit_d     = edit_nxt;
                res_o.kind = KIND_ECHO;
                res_o.data = ch;
                if (ch == CH_LF || ch == CH_CTRL_D ||
                    idx_diff(edit_nxt, read_q) == DEPTH_I) begin
                  commit_d    = edit_nxt;
                  res_o.ready = 1'b1;
                end
              end
            end
          end else begin
            if (read_q == commit_q) begin
              res_o.kind = KIND_EMPTY;
            end else begin
              res_valid_o = 1'b0;
              mem_re_o    = 1'b1;
              first_d     = first_of_read_i;
            end
          end
        end
      end
      ST_READ: begin
        res_valid_o = 1'b1;
        res_o.done  = 1'b1;
        if (rb == CH_CTRL_D) begin
          if (first_q) begin
            read_d = idx_inc(read_q);
          end
          res_o.kind = KIND_EOF;
        end else begin
          read_d     = idx_inc(read_q);
          res_o.kind = KIND_DATA;
          res_o.data = rb;
          res_o.done = (rb == CH_LF);
        end
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      read_q   <= '0;
      commit_q <= '0;
      edit_q   <= '0;
    end else begin
      state_q  <= state_d;
      read_q   <= read_d;
      commit_q <= commit_d;
      edit_q   <= edit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

  assign busy_o = (state_q == ST_READ);

  `CLB_ASSERT_IMP(a_commit_in_span, 1'b1,
                  idx_diff(commit_q, read_q) <= idx_diff(edit_q, read_q))
  `CLB_ASSERT_IMP(a_fill_bound, 1'b1, idx_diff(edit_q, read_q) <= DEPTH_I)
  `CLB_ASSERT_NXT(a_read_one_cycle, state_q == ST_READ, state_q == ST_IDLE)
  `CLB_ASSERT_IMP(a_data_after_fetch,
                  res_valid_o && (res_o.kind == KIND_DATA || res_o.kind == KIND_EOF),
                  $past(mem_re_o))

endmodule

FILE: rtl/console_line_edit_buffer.sv
// A received byte or a read of an empty buffer gives a registered result
// in the cycle after acceptance; a read of a committed byte is registered
// in the line store memory's read port and then in the output register.
// Throughput: one request per cycle for received bytes; a data read stalls
// input during its fetch; a waiting result stalls input only if not taken.
// Reset: asynchronous, active low; indices clear, the line store does not.
module console_line_edit_buffer
  import clb_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       first_of_read_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] erase_count_o,
  output logic       read_done_o,
  output logic       line_ready_o
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic          in_accept;
  logic          busy;
  logic          res_valid;
  res_t          res;
  res_t          out_res_q;
  logic          out_valid_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  clb_ctrl #(
    .BUF_DEPTH(BUF_DEPTH),
    .AW       (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_accept_i    (in_accept),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .first_of_read_i(first_of_read_i),
    .busy_o         (busy),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  clb_ram #(
    .DEPTH(BUF_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_res_q.kind;
  assign data_byte_o   = out_res_q.data;
  assign erase_count_o = out_res_q.erase;
  assign read_done_o   = out_res_q.done;
  assign line_ready_o  = out_res_q.ready;

endmodule
